@@ design/slf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants for the serial link framer.
// Used by the channel interfaces, the front and back parts and the top level.
package slf_pkg;

  // Default depth of each of the two byte FIFOs.
  localparam int FIFO_DEPTH_DEF = 256;

  // Width of the count fields in a result item.
  localparam int COUNT_W = 9;

  // Escape byte of the link framing.
  localparam logic [7:0] ESC_BYTE = 8'hff;

  // Escape payloads that carry the peer nCTS level.
  localparam logic [7:0] CTS_ACTIVE_CODE   = 8'h00;
  localparam logic [7:0] CTS_INACTIVE_CODE = 8'h01;

  // Item kinds.
  localparam logic [2:0] KIND_LINK_RX = 3'd0;
  localparam logic [2:0] KIND_WRITE   = 3'd1;
  localparam logic [2:0] KIND_READ    = 3'd2;
  localparam logic [2:0] KIND_TICK    = 3'd3;
  localparam logic [2:0] KIND_SET_RTS = 3'd4;
  localparam logic [2:0] KIND_CONNECT = 3'd5;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       level;
  } in_item_t;

  typedef struct packed {
    logic               link_valid;
    logic [7:0]         link_byte;
    logic               read_valid;
    logic [7:0]         read_byte;
    logic               write_accepted;
    logic [COUNT_W-1:0] input_count;
    logic [COUNT_W-1:0] output_free;
    logic               input_overflow;
    logic               peer_not_clear;
    logic               last;
  } out_item_t;

  // Everything the back part needs to emit the results of one item.
  typedef struct packed {
    logic [1:0]         nlink;
    logic [7:0]         byte0;
    logic [7:0]         byte1;
    logic               rvalid;
    logic [7:0]         rbyte;
    logic               waccept;
    logic [COUNT_W-1:0] in_count;
    logic [COUNT_W-1:0] out_free;
    logic               ovf;
    logic               cts;
  } res_rec_t;

  // A record still waiting for FIFO read data.
  typedef struct packed {
    res_rec_t rec;
    logic     tick_mem;
    logic     read_mem;
  } pend_t;

endpackage

@@ design/slf_in_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel that carries input items into the framer.
// Depends on slf_pkg for the payload type.
interface slf_in_if;
  logic             valid;
  logic             ready;
  slf_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/slf_out_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel that carries result items out of the framer.
// Depends on slf_pkg for the payload type.
interface slf_out_if;
  logic              valid;
  logic              ready;
  slf_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/slf_front.sv @@
`timescale 1ns / 1ps
// Front part: accepts items, keeps the link and FIFO state and both byte memories,
// and hands one result record per item to the back part. Depends on slf_pkg.
module slf_front #(
  parameter int FIFO_DEPTH = slf_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  slf_in_if.sink           cmd,
  input  logic             room,
  output logic             push,
  output slf_pkg::res_rec_t push_rec
);

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);
  localparam int OutW = slf_pkg::COUNT_W;
  localparam logic [PtrW-1:0] LastIdx = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] Full = CntW'(FIFO_DEPTH);

  // Byte memories; contents are only read where written.
  logic [7:0] in_mem  [FIFO_DEPTH];
  logic [7:0] out_mem [FIFO_DEPTH];

  logic [PtrW-1:0] in_head, in_tail, out_head, out_tail;
  logic [CntW-1:0] in_fill, out_fill;
  logic            overflow, esc_pending, cts_inactive, link_up;

  logic [PtrW-1:0] in_head_next, in_tail_next, out_head_next, out_tail_next;
  logic [CntW-1:0] in_fill_next, out_fill_next;
  logic            overflow_next, esc_pending_next, cts_inactive_next, link_up_next;

  logic            acc;
  logic            in_wr, out_wr, in_rd, out_rd;
  logic [7:0]      in_rd_data, out_rd_data;
  logic            pend_valid;
  slf_pkg::pend_t  pend, pend_next;

  // No item is taken while reset is held.
  assign cmd.ready = room && !rst;
  assign acc = cmd.valid && cmd.ready;

  // Classify the item and work out the next state and its result record.
  always_comb begin
    logic store;
    store             = 1'b0;
    in_head_next      = in_head;
    in_tail_next      = in_tail;
    in_fill_next      = in_fill;
    out_head_next     = out_head;
    out_tail_next     = out_tail;
    out_fill_next     = out_fill;
    overflow_next     = overflow;
    esc_pending_next  = esc_pending;
    cts_inactive_next = cts_inactive;
    link_up_next      = link_up;
    in_wr             = 1'b0;
    out_wr            = 1'b0;
    in_rd             = 1'b0;
    out_rd            = 1'b0;
    pend_next         = '0;

    if (acc) begin
      case (cmd.data.kind)
        slf_pkg::KIND_LINK_RX: begin
          if (link_up) begin
            if (esc_pending) begin
              esc_pending_next = 1'b0;
              if (cmd.data.data_byte == slf_pkg::CTS_ACTIVE_CODE) begin
                cts_inactive_next = 1'b0;
              end else if (cmd.data.data_byte == slf_pkg::CTS_INACTIVE_CODE) begin
                cts_inactive_next = 1'b1;
              end else begin
                store = 1'b1;
              end
            end else if (cmd.data.data_byte == slf_pkg::ESC_BYTE) begin
              esc_pending_next = 1'b1;
            end else begin
              store = 1'b1;
            end
          end
          if (store) begin
            if (in_fill == Full) begin
              overflow_next = 1'b1;
            end else begin
              in_wr        = 1'b1;
              in_tail_next = (in_tail == LastIdx) ? '0 : in_tail + 1'b1;
              in_fill_next = in_fill + 1'b1;
            end
          end
        end
        slf_pkg::KIND_WRITE: begin
          if (out_fill != Full) begin
            out_wr                = 1'b1;
            out_tail_next         = (out_tail == LastIdx) ? '0 : out_tail + 1'b1;
            out_fill_next         = out_fill + 1'b1;
            pend_next.rec.waccept = 1'b1;
          end
        end
        slf_pkg::KIND_READ: begin
          if (in_fill != '0) begin
            in_rd                = 1'b1;
            in_head_next         = (in_head == LastIdx) ? '0 : in_head + 1'b1;
            in_fill_next         = in_fill - 1'b1;
            overflow_next        = 1'b0;
            pend_next.rec.rvalid = 1'b1;
            pend_next.read_mem   = 1'b1;
          end
        end
        slf_pkg::KIND_TICK: begin
          if (link_up && !cts_inactive && out_fill != '0) begin
            out_rd              = 1'b1;
            out_head_next       = (out_head == LastIdx) ? '0 : out_head + 1'b1;
            out_fill_next       = out_fill - 1'b1;
            pend_next.rec.nlink = 2'd1;
            pend_next.tick_mem  = 1'b1;
          end
        end
        slf_pkg::KIND_SET_RTS: begin
          // The RTS level is only ever observed in this announcement.
          if (link_up) begin
            pend_next.rec.nlink = 2'd2;
            pend_next.rec.byte0 = slf_pkg::ESC_BYTE;
            pend_next.rec.byte1 = {7'd0, cmd.data.level};
          end
        end
        slf_pkg::KIND_CONNECT: begin
          if (cmd.data.level) begin
            if (!link_up) begin
              link_up_next        = 1'b1;
              in_head_next        = '0;
              in_tail_next        = '0;
              in_fill_next        = '0;
              out_head_next       = '0;
              out_tail_next       = '0;
              out_fill_next       = '0;
              overflow_next       = 1'b0;
              pend_next.rec.nlink = 2'd2;
              pend_next.rec.byte0 = slf_pkg::ESC_BYTE;
              pend_next.rec.byte1 = slf_pkg::CTS_INACTIVE_CODE;
            end
          end else begin
            link_up_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    pend_next.rec.in_count = OutW'(in_fill_next);
    pend_next.rec.out_free = OutW'(Full - out_fill_next);
    pend_next.rec.ovf      = overflow_next;
    pend_next.rec.cts      = cts_inactive_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_head      <= '0;
      in_tail      <= '0;
      in_fill      <= '0;
      out_head     <= '0;
      out_tail     <= '0;
      out_fill     <= '0;
      overflow     <= 1'b0;
      esc_pending  <= 1'b0;
      cts_inactive <= 1'b1;
      link_up      <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      in_head      <= in_head_next;
      in_tail      <= in_tail_next;
      in_fill      <= in_fill_next;
      out_head     <= out_head_next;
      out_tail     <= out_tail_next;
      out_fill     <= out_fill_next;
      overflow     <= overflow_next;
      esc_pending  <= esc_pending_next;
      cts_inactive <= cts_inactive_next;
      link_up      <= link_up_next;
      pend_valid   <= acc;
    end
  end

  // Record that waits for the memory read data.
  always_ff @(posedge clk) begin
    if (acc) begin
      pend <= pend_next;
    end
  end

  // Received-byte memory.
  always_ff @(posedge clk) begin
    if (in_wr) begin
      in_mem[in_tail] <= cmd.data.data_byte;
    end
    if (in_rd) begin
      in_rd_data <= in_mem[in_head];
    end
  end

  // Host-byte memory.
  always_ff @(posedge clk) begin
    if (out_wr) begin
      out_mem[out_tail] <= cmd.data.data_byte;
    end
    if (out_rd) begin
      out_rd_data <= out_mem[out_head];
    end
  end

  // Fill in the bytes read from memory; a sent 0xff goes out twice.
  always_comb begin
    push_rec = pend.rec;
    if (pend.read_mem) begin
      push_rec.rbyte = in_rd_data;
    end
    if (pend.tick_mem) begin
      push_rec.byte0 = out_rd_data;
      push_rec.byte1 = out_rd_data;
      push_rec.nlink = (out_rd_data == slf_pkg::ESC_BYTE) ? 2'd2 : 2'd1;
    end
  end

  assign push = pend_valid;

endmodule

@@ design/slf_back.sv @@
`timescale 1ns / 1ps
// Back part: a short queue of result records and the output register that
// turns each record into one or two result items. Depends on slf_pkg.
module slf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  slf_pkg::res_rec_t push_rec,
  output logic             room,
  slf_out_if.source        result
);

  localparam int QD   = slf_pkg::QUEUE_DEPTH;
  localparam int QPW  = $clog2(QD);
  localparam int QCW  = $clog2(QD + 1);

  slf_pkg::res_rec_t q [QD];
  logic [QPW-1:0]    wr_ptr, rd_ptr;
  logic [QCW-1:0]    q_count;
  logic              phase;
  logic              load, pop;
  slf_pkg::res_rec_t head;
  slf_pkg::out_item_t first_item, second_item;

  // Room for the record in flight plus one more accepted item.
  assign room = (q_count <= QCW'(QD - 2));

  assign head = q[rd_ptr];
  assign load = !result.valid || result.ready;

  // First and second result items of the record at the queue head.
  always_comb begin
    first_item.link_valid     = (head.nlink != 2'd0);
    first_item.link_byte      = (head.nlink != 2'd0) ? head.byte0 : 8'd0;
    first_item.read_valid     = head.rvalid;
    first_item.read_byte      = head.rbyte;
    first_item.write_accepted = head.waccept;
    first_item.input_count    = head.in_count;
    first_item.output_free    = head.out_free;
    first_item.input_overflow = head.ovf;
    first_item.peer_not_clear = head.cts;
    first_item.last           = (head.nlink != 2'd2);
    second_item               = first_item;
    second_item.link_valid    = 1'b1;
    second_item.link_byte     = head.byte1;
    second_item.last          = 1'b1;
  end

  assign pop = load && (phase || (q_count != '0 && head.nlink != 2'd2));

  // Queue pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      q_count <= q_count + QCW'(push) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_rec;
    end
  end

  // Output register and the phase of a two-item record.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      phase        <= 1'b0;
    end else if (load) begin
      if (phase) begin
        result.valid <= 1'b1;
        phase        <= 1'b0;
      end else if (q_count != '0) begin
        result.valid <= 1'b1;
        phase        <= (head.nlink == 2'd2);
      end else begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.data <= phase ? second_item : first_item;
    end
  end

endmodule

@@ design/ip232_serial_link_framer_unit.sv @@
`timescale 1ns / 1ps
// Results pass through the pending record, the queue and the output register.
// Throughput: one input item per cycle while the queue has room; an item with
// two link bytes leaves the single output register as two items. A four-entry
// queue lets the front keep accepting while results wait. Reset is synchronous
// and clears all control state; the two byte FIFO memories are not cleared.
module ip232_serial_link_framer_unit #(
  parameter int FIFO_DEPTH = slf_pkg::FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  slf_in_if.sink    cmd,
  slf_out_if.source result
);

  logic              room;
  logic              push;
  slf_pkg::res_rec_t push_rec;

  slf_front #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .room     (room),
    .push     (push),
    .push_rec (push_rec)
  );

  slf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .room     (room),
    .result   (result)
  );

endmodule

@@ design/slf_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the framer's result channel, and the bind that
// attaches them to the top level. Depends on slf_pkg.
module slf_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input slf_pkg::out_item_t res_data
);

  // A stalled result item holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result payload changed while stalled");

  // The second link byte of a pair follows right after the first.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_data.last |=>
      res_valid && res_data.link_valid && res_data.last)
    else $error("second item of a pair missing");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A read and a write never report in the same item.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.read_valid && res_data.write_accepted))
    else $error("read and write reported together");

endmodule

bind ip232_serial_link_framer_unit slf_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);

@@ tb/ip232_serial_link_framer_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the serial link framer: a directed table, then random
// escape-framed traffic, host FIFO traffic and ticks, checked against a model.
// Depends on slf_pkg, slf_in_if, slf_out_if and ip232_serial_link_framer_unit.
module ip232_serial_link_framer_unit_tb;

  localparam int DEPTH = slf_pkg::FIFO_DEPTH_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_PRINTED = 100;
  localparam logic [2:0] KIND_NOP = 3'd6;

  // One row of the directed table; n_typed > 0 means the results are written out.
  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         data;
    logic               level;
    logic [1:0]         n_typed;
    slf_pkg::out_item_t e0;
    slf_pkg::out_item_t e1;
  } step_row_t;

  logic clk;
  logic rst;

  slf_in_if cmd_if ();
  slf_out_if res_if ();

  ip232_serial_link_framer_unit #(
    .FIFO_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .result(res_if)
  );

  // Model of the link endpoint.
  logic [7:0] rx_mem [DEPTH];
  logic [7:0] tx_mem [DEPTH];
  int   rx_head, rx_tail, rx_fill;
  int   tx_head, tx_tail, tx_fill;
  logic rx_ovf, esc_pending, cts_off, rts_off, link_on;

  slf_pkg::out_item_t expected_results [$];
  step_row_t dir_rows [$];

  int   items_sent;
  int   results_seen;
  int   link_bytes_seen;
  int   tx_rejects;
  int   rx_drops;
  int   mismatches;
  int   stall_cycles;
  bit   no_idle;
  bit   hold_off_req;
  bit   holding;

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic slf_pkg::out_item_t res_item(logic lv, logic [7:0] lb, logic rv,
                                                  logic [7:0] rb, logic wa, int ic,
                                                  int ofree, logic ovf, logic pnc,
                                                  logic lst);
    slf_pkg::out_item_t r;
    r.link_valid     = lv;
    r.link_byte      = lb;
    r.read_valid     = rv;
    r.read_byte      = rb;
    r.write_accepted = wa;
    r.input_count    = slf_pkg::COUNT_W'(ic);
    r.output_free    = slf_pkg::COUNT_W'(ofree);
    r.input_overflow = ovf;
    r.peer_not_clear = pnc;
    r.last           = lst;
    return r;
  endfunction

  function automatic void add_row(logic [2:0] kind, logic [7:0] data, logic level,
                                  logic [1:0] n_typed, slf_pkg::out_item_t e0,
                                  slf_pkg::out_item_t e1);
    step_row_t row;
    row.kind    = kind;
    row.data    = data;
    row.level   = level;
    row.n_typed = n_typed;
    row.e0      = e0;
    row.e1      = e1;
    dir_rows.push_back(row);
  endfunction

  // A received byte enters the input FIFO, or is dropped and flagged when full.
  function automatic void rx_push(logic [7:0] b);
    if (rx_fill >= DEPTH) begin
      rx_ovf = 1'b1;
      rx_drops++;
    end else begin
      rx_mem[rx_tail] = b;
      rx_tail = (rx_tail + 1) % DEPTH;
      rx_fill++;
    end
  endfunction

  // Applies one input item to the model and returns how many results it gives.
  function automatic int predict_item(input logic [2:0] kind, input logic [7:0] data,
                                      input logic level, output slf_pkg::out_item_t r0,
                                      output slf_pkg::out_item_t r1);
    int         nlink;
    int         cnt;
    logic [7:0] lb0, lb1;
    logic       rv, wa;
    logic [7:0] rb;
    nlink = 0;
    lb0 = 8'h00;
    lb1 = 8'h00;
    rv = 1'b0;
    rb = 8'h00;
    wa = 1'b0;
    case (kind)
      slf_pkg::KIND_LINK_RX: begin
        if (link_on) begin
          if (esc_pending) begin
            esc_pending = 1'b0;
            if (data == slf_pkg::CTS_ACTIVE_CODE) cts_off = 1'b0;
            else if (data == slf_pkg::CTS_INACTIVE_CODE) cts_off = 1'b1;
            else rx_push(data);
          end else if (data == slf_pkg::ESC_BYTE) begin
            esc_pending = 1'b1;
          end else begin
            rx_push(data);
          end
        end
      end
      slf_pkg::KIND_WRITE: begin
        if (tx_fill < DEPTH) begin
          tx_mem[tx_tail] = data;
          tx_tail = (tx_tail + 1) % DEPTH;
          tx_fill++;
          wa = 1'b1;
        end else begin
          tx_rejects++;
        end
      end
      slf_pkg::KIND_READ: begin
        if (rx_fill > 0) begin
          rb = rx_mem[rx_head];
          rx_head = (rx_head + 1) % DEPTH;
          rx_fill--;
          rv = 1'b1;
          rx_ovf = 1'b0;
        end
      end
      slf_pkg::KIND_TICK: begin
        if (link_on && !cts_off && tx_fill > 0) begin
          lb0 = tx_mem[tx_head];
          lb1 = lb0;
          tx_head = (tx_head + 1) % DEPTH;
          tx_fill--;
          nlink = (lb0 == slf_pkg::ESC_BYTE) ? 2 : 1;
        end
      end
      slf_pkg::KIND_SET_RTS: begin
        rts_off = level;
        if (link_on) begin
          lb0 = slf_pkg::ESC_BYTE;
          lb1 = {7'd0, rts_off};
          nlink = 2;
        end
      end
      slf_pkg::KIND_CONNECT: begin
        if (level) begin
          if (!link_on) begin
            link_on = 1'b1;
            rx_head = 0;
            rx_tail = 0;
            rx_fill = 0;
            tx_head = 0;
            tx_tail = 0;
            tx_fill = 0;
            rx_ovf = 1'b0;
            rts_off = 1'b1;
            lb0 = slf_pkg::ESC_BYTE;
            lb1 = slf_pkg::CTS_INACTIVE_CODE;
            nlink = 2;
          end
        end else begin
          link_on = 1'b0;
        end
      end
      default: ;
    endcase
    cnt = (nlink == 2) ? 2 : 1;
    r0 = res_item(nlink > 0, (nlink > 0) ? lb0 : 8'h00, rv, rb, wa, rx_fill, DEPTH - tx_fill,
                  rx_ovf, cts_off, cnt == 1);
    r1 = res_item(nlink > 1, (nlink > 1) ? lb1 : 8'h00, rv, rb, wa, rx_fill, DEPTH - tx_fill,
                  rx_ovf, cts_off, 1'b1);
    return cnt;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one item, waits for acceptance, then records what it should cause.
  task automatic send_item(input logic [2:0] kind, input logic [7:0] data, input logic level,
                           input logic [1:0] n_typed = 2'd0,
                           input slf_pkg::out_item_t e0 = '0,
                           input slf_pkg::out_item_t e1 = '0);
    slf_pkg::in_item_t  it;
    slf_pkg::out_item_t p0, p1;
    int                 gap;
    int                 cnt;
    it.kind = kind;
    it.data_byte = data;
    it.level = level;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= it;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    cnt = predict_item(kind, data, level, p0, p1);
    if (n_typed == 2'd0) begin
      expected_results.push_back(p0);
      if (cnt == 2) expected_results.push_back(p1);
    end else begin
      expected_results.push_back(e0);
      if (n_typed == 2'd2) expected_results.push_back(e1);
    end
    items_sent++;
  endtask

  // One burst of traffic of a given flavor.
  task automatic random_burst(input int sel, input int len);
    int         r;
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (sel)
        0: begin
          // Escape-framed link traffic with random content.
          r = $urandom_range(0, 99);
          if (r < 60) begin
            b = 8'($urandom_range(0, 254));
            send_item(slf_pkg::KIND_LINK_RX, b, 1'($urandom));
          end else begin
            send_item(slf_pkg::KIND_LINK_RX, slf_pkg::ESC_BYTE, 1'($urandom));
            if (r < 75) b = slf_pkg::ESC_BYTE;
            else if (r < 85) b = slf_pkg::CTS_ACTIVE_CODE;
            else if (r < 90) b = slf_pkg::CTS_INACTIVE_CODE;
            else b = 8'($urandom_range(2, 254));
            send_item(slf_pkg::KIND_LINK_RX, b, 1'($urandom));
          end
        end
        1: begin
          b = ($urandom_range(0, 4) == 0) ? slf_pkg::ESC_BYTE : 8'($urandom);
          send_item(slf_pkg::KIND_WRITE, b, 1'($urandom));
        end
        2: send_item(slf_pkg::KIND_READ, 8'($urandom), 1'($urandom));
        3: send_item(slf_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
        4: send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
        5: send_item(slf_pkg::KIND_SET_RTS, 8'($urandom), 1'($urandom));
        default: begin
          // Reconnect soon after a drop; disconnect now and then.
          if (link_on) b = ($urandom_range(0, 3) != 0) ? 8'd1 : 8'd0;
          else b = ($urandom_range(0, 9) != 0) ? 8'd1 : 8'd0;
          send_item(slf_pkg::KIND_CONNECT, 8'($urandom), b[0]);
        end
      endcase
    end
  endtask

  // Short random bursts until the item count reaches a mark.
  task automatic small_bursts(input int until_items);
    int r;
    int sel;
    int nb;
    nb = 0;
    while (items_sent < until_items) begin
      r = $urandom_range(0, 99);
      if (r < 25) sel = 0;
      else if (r < 45) sel = 1;
      else if (r < 60) sel = 2;
      else if (r < 80) sel = 3;
      else if (r < 90) sel = 4;
      else if (r < 95) sel = 5;
      else sel = 6;
      nb++;
      no_idle = (nb % 7 == 0);
      random_burst(sel, $urandom_range(1, 8));
    end
    no_idle = 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    slf_pkg::out_item_t got;
    slf_pkg::out_item_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result item with nothing expected: 0x%0h", got));
      end else begin
        want = expected_results.pop_front();
        check_field("link_valid", 9'(got.link_valid), 9'(want.link_valid));
        check_field("link_byte", 9'(got.link_byte), 9'(want.link_byte));
        check_field("read_valid", 9'(got.read_valid), 9'(want.read_valid));
        check_field("read_byte", 9'(got.read_byte), 9'(want.read_byte));
        check_field("write_accepted", 9'(got.write_accepted), 9'(want.write_accepted));
        check_field("input_count", 9'(got.input_count), 9'(want.input_count));
        check_field("output_free", 9'(got.output_free), 9'(want.output_free));
        check_field("input_overflow", 9'(got.input_overflow), 9'(want.input_overflow));
        check_field("peer_not_clear", 9'(got.peer_not_clear), 9'(want.peer_not_clear));
        check_field("last", 9'(got.last), 9'(want.last));
      end
      if (got.link_valid === 1'b1) link_bytes_seen++;
      results_seen++;
    end
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: nothing moved for %0d cycles, %0d results outstanding.",
                 stall_cycles, expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result-side ready: random gaps, plus one long hold-off on request.
  initial begin
    int span;
    res_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        holding = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        holding = 1'b0;
      end else begin
        span = pick_gap();
        if (span > 0) begin
          res_if.ready <= 1'b0;
          repeat (span) @(posedge clk);
        end
        res_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    slf_pkg::out_item_t idle_st;
    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    no_idle = 1'b0;
    hold_off_req = 1'b0;
    holding = 1'b0;
    items_sent = 0;
    results_seen = 0;
    link_bytes_seen = 0;
    tx_rejects = 0;
    rx_drops = 0;
    mismatches = 0;
    stall_cycles = 0;
    rx_head = 0;
    rx_tail = 0;
    rx_fill = 0;
    tx_head = 0;
    tx_tail = 0;
    tx_fill = 0;
    rx_ovf = 1'b0;
    esc_pending = 1'b0;
    cts_off = 1'b1;
    rts_off = 1'b1;
    link_on = 1'b0;

    // Directed table: the first rows start from reset and are written out.
    idle_st = res_item(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 0, DEPTH, 1'b0, 1'b1, 1'b1);
    add_row(KIND_NOP, 8'hff, 1'b1, 2'd1, idle_st, '0);
    add_row(slf_pkg::KIND_READ, 8'h00, 1'b0, 2'd1, idle_st, '0);
    add_row(slf_pkg::KIND_TICK, 8'ha5, 1'b1, 2'd1, idle_st, '0);
    add_row(slf_pkg::KIND_LINK_RX, 8'hab, 1'b0, 2'd1, idle_st, '0);
    add_row(slf_pkg::KIND_SET_RTS, 8'h00, 1'b0, 2'd1, idle_st, '0);
    add_row(slf_pkg::KIND_WRITE, 8'h00, 1'b1, 2'd1,
            res_item(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 0, DEPTH - 1, 1'b0, 1'b1, 1'b1), '0);
    add_row(slf_pkg::KIND_WRITE, 8'hff, 1'b0, 2'd1,
            res_item(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 0, DEPTH - 2, 1'b0, 1'b1, 1'b1), '0);
    add_row(slf_pkg::KIND_CONNECT, 8'h00, 1'b0, 2'd1,
            res_item(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 0, DEPTH - 2, 1'b0, 1'b1, 1'b1), '0);
    // Connecting flushes both FIFOs and announces RTS inactive.
    add_row(slf_pkg::KIND_CONNECT, 8'h00, 1'b1, 2'd2,
            res_item(1'b1, slf_pkg::ESC_BYTE, 1'b0, 8'h00, 1'b0, 0, DEPTH, 1'b0, 1'b1,
                     1'b0),
            res_item(1'b1, slf_pkg::CTS_INACTIVE_CODE, 1'b0, 8'h00, 1'b0, 0, DEPTH, 1'b0,
                     1'b1, 1'b1));
    add_row(slf_pkg::KIND_CONNECT, 8'hff, 1'b1, 2'd1, idle_st, '0);
    // Escape handling, doubled output, ticks while not clear, RTS while connected.
    add_row(slf_pkg::KIND_LINK_RX, slf_pkg::ESC_BYTE, 1'b0, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_LINK_RX, slf_pkg::CTS_ACTIVE_CODE, 1'b1, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_WRITE, 8'hff, 1'b0, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_WRITE, 8'h5a, 1'b1, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_TICK, 8'h00, 1'b0, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_TICK, 8'hff, 1'b1, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_TICK, 8'h3c, 1'b0, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_LINK_RX, slf_pkg::ESC_BYTE, 1'b0, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_LINK_RX, slf_pkg::ESC_BYTE, 1'b1, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_LINK_RX, 8'h00, 1'b0, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_LINK_RX, slf_pkg::ESC_BYTE, 1'b0, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_LINK_RX, 8'h7e, 1'b1, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_WRITE, 8'h81, 1'b0, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_LINK_RX, slf_pkg::ESC_BYTE, 1'b1, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_LINK_RX, slf_pkg::CTS_INACTIVE_CODE, 1'b0, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_TICK, 8'h00, 1'b1, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_READ, 8'hff, 1'b1, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_SET_RTS, 8'hff, 1'b1, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_SET_RTS, 8'h00, 1'b0, 2'd0, '0, '0);
    // A pending escape survives a disconnect and reconnect.
    add_row(slf_pkg::KIND_LINK_RX, slf_pkg::ESC_BYTE, 1'b0, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_CONNECT, 8'h00, 1'b0, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_CONNECT, 8'h00, 1'b1, 2'd0, '0, '0);
    add_row(slf_pkg::KIND_LINK_RX, slf_pkg::CTS_ACTIVE_CODE, 1'b1, 2'd0, '0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].level, dir_rows[i].n_typed,
                dir_rows[i].e0, dir_rows[i].e1);
    end

    small_bursts(300);

    // Long hold-off on results while items keep coming, so the input stalls.
    cmd_if.valid <= 1'b0;
    hold_off_req = 1'b1;
    @(posedge clk);
    while (!holding) @(posedge clk);
    no_idle = 1'b1;
    random_burst(4, 40);
    no_idle = 1'b0;

    small_bursts(500);

    // Fill and drain both FIFOs past their limits.
    send_item(slf_pkg::KIND_CONNECT, 8'($urandom), 1'b1);
    send_item(slf_pkg::KIND_LINK_RX, slf_pkg::CTS_ACTIVE_CODE, 1'b0);
    send_item(slf_pkg::KIND_LINK_RX, slf_pkg::ESC_BYTE, 1'b1);
    send_item(slf_pkg::KIND_LINK_RX, slf_pkg::CTS_ACTIVE_CODE, 1'b0);
    random_burst(1, DEPTH + 14);
    random_burst(3, DEPTH + 44);
    random_burst(0, DEPTH + 44);
    random_burst(2, DEPTH + 64);

    small_bursts(1700);

    cmd_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d input items and %0d result items, %0d of them link bytes.",
             items_sent, results_seen, link_bytes_seen);
    $display("Writes refused on a full output FIFO: %0d; received bytes dropped: %0d.",
             tx_rejects, rx_drops);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/slf_pkg.sv
design/slf_in_if.sv
design/slf_out_if.sv
design/slf_front.sv
design/slf_back.sv
design/ip232_serial_link_framer_unit.sv
design/slf_checker.sv
tb/ip232_serial_link_framer_unit_tb.sv
